@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the section table core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset
`define SST_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("section table assertion failed");
// Check that a condition implies a consequence in the next cycle
`define SST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("section table assertion failed");
`else
`define SST_ASSERT(label, clk, rst, prop)
`define SST_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ design/sst_pkg.sv @@
// ----------------------------------------------------------------------------
// Section table package
// Widths, operation and status codes and entry types of the section table.
// ----------------------------------------------------------------------------
package sst_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = IDX_W + 1;

   // Field widths
   localparam int OFF_W  = 31;
   localparam int WORD_W = 32;

   localparam logic [WORD_W-1:0] SEI_PREFIX_FLAG = 32'h1000_0000;
   localparam logic [WORD_W-1:0] ALL_ONES        = 32'hffff_ffff;
   localparam logic [CNT_W-1:0]  CAP_RESET       = CNT_W'(TABLE_DEPTH);
   localparam logic [CNT_W-1:0]  IDX_NONE        = '1;

   // Operation codes
   typedef enum logic [2:0] {
      FN_ADD         = 3'd0,
      FN_CHANGE      = 3'd1,
      FN_SET_FLAGS   = 3'd2,
      FN_CLEAR       = 3'd3,
      FN_LAST_MASK   = 3'd4,
      FN_ADD_SEI     = 3'd5,
      FN_UNUSED_PART = 3'd6
   } func_type;

   // Result status codes
   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_FULL    = 2'd1,
      STAT_BAD_IDX = 2'd2
   } status_type;

   // Entry words other than the flags
   typedef struct packed {
      logic [OFF_W-1:0]  offset;
      logic [OFF_W-1:0]  length;
      logic [WORD_W-1:0] aux_a;
      logic [WORD_W-1:0] aux_b;
   } entry_type;

   // Write request into the entry store
   typedef struct packed {
      logic              flags_en;
      logic              data_en;
      logic [IDX_W-1:0]  addr;
      logic [WORD_W-1:0] flags;
      entry_type         data;
   } wr_type;

endpackage

@@ design/sst_store.sv @@
// ----------------------------------------------------------------------------
// Section table entry store
// Flags memory and entry word memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module sst_store
   import sst_pkg::*;
(
   input  logic              clock,
   input  wr_type            wr,
   input  logic              rd_en,
   input  logic [IDX_W-1:0]  rd_addr,
   output logic [WORD_W-1:0] rd_flags,
   output entry_type         rd_data
);

   logic [WORD_W-1:0] flags_mem [TABLE_DEPTH];
   entry_type         data_mem  [TABLE_DEPTH];
   logic [WORD_W-1:0] rd_flags_ff;
   entry_type         rd_data_ff;

   // Write flags and entry words independently
   always_ff @(posedge clock) begin
      if (wr.flags_en) begin
         flags_mem[wr.addr] <= wr.flags;
      end
      if (wr.data_en) begin
         data_mem[wr.addr] <= wr.data;
      end
   end

   // Register read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_flags_ff <= flags_mem[rd_addr];
         rd_data_ff  <= data_mem[rd_addr];
      end
   end

   assign rd_flags = rd_flags_ff;
   assign rd_data  = rd_data_ff;

endmodule

@@ design/stream_section_table_core.sv @@
// ----------------------------------------------------------------------------
// Stream section table core
// Ordered table of bitstream section descriptors with append, change, flag
// update, clear, mask search, SEI insert and end-of-data query.
// ----------------------------------------------------------------------------
// Each request transfer carries one table operation and yields exactly one
// response transfer. The entries live in a single-port-read memory, so every
// operation that looks at entries walks them one per cycle from the highest
// index down. Append, change, set flags, clear and suffix SEI go from IDLE to
// RESP; mask search and the end-of-data query walk the entries in SCAN; a
// prefix SEI insert reads and moves one entry per cycle in SCAN, then writes
// the new entry in PUT. A new request is taken once the previous result sits
// in the response register. capacity is to be written through csr_wen /
// csr_wdata while the core is idle, unchecked by the core; values above
// the table depth act as the depth, and zero makes the table always full.
`include "assert_macros.svh"

module stream_section_table_core
   import sst_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // request
   input  logic         req_tvalid,
   output logic         req_tready,
   // section_index[5:0], offset[36:6], length[67:37], flags[99:68],
   // aux_a[131:100], aux_b[163:132], zero[167:164]
   input  logic [167:0] req_tdata,
   // func[2:0], is_prefix[3]
   input  logic [3:0]   req_tuser,
   // response
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // result_index[6:0], result_value[38:7], status[40:39], zero[47:41]
   output logic [47:0]  rsp_tdata,
   // configuration
   input  logic         csr_wen,
   input  logic [6:0]   csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_PUT  = 4'b0100,
      ST_RESP = 4'b1000
   } state_type;

   // Request fields
   func_type          req_func;
   logic              req_prefix;
   logic [IDX_W-1:0]  req_sidx;
   logic [OFF_W-1:0]  req_off;
   logic [OFF_W-1:0]  req_len;
   logic [WORD_W-1:0] req_flags;
   logic [WORD_W-1:0] req_aux_a;
   logic [WORD_W-1:0] req_aux_b;
   logic              req_xfer;

   // Control and payload registers
   state_type         state_ff,   state_in;
   func_type          op_ff,      op_in;
   logic [CNT_W-1:0]  cnt_ff,     cnt_in;
   logic [CNT_W-1:0]  cap_ff;
   logic [IDX_W-1:0]  idx_ff,     idx_in;
   logic [IDX_W-1:0]  pos_ff,     pos_in;
   logic [WORD_W-1:0] mask_ff,    mask_in;
   logic [WORD_W-1:0] max_ff,     max_in;
   logic [OFF_W-1:0]  new_off_ff;
   logic [OFF_W-1:0]  new_len_ff;
   logic [WORD_W-1:0] new_a_ff;
   logic [CNT_W-1:0]  res_idx_ff, res_idx_in;
   logic [WORD_W-1:0] res_val_ff, res_val_in;
   status_type        res_st_ff,  res_st_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]  rsp_idx_ff;
   logic [WORD_W-1:0] rsp_val_ff;
   status_type        rsp_st_ff;

   // Store access
   wr_type            wr;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [WORD_W-1:0] rd_flags;
   entry_type         rd_data;

   // Derived conditions
   logic              full;
   logic              bad_idx;
   logic              scan_last;
   logic [WORD_W-1:0] scan_end;
   logic [WORD_W-1:0] scan_max;
   logic [IDX_W-1:0]  top_idx;
   logic              rsp_load;

   // Unpack request
   assign req_func   = func_type'(req_tuser[2:0]);
   assign req_prefix = req_tuser[3];
   assign req_sidx   = req_tdata[5:0];
   assign req_off    = req_tdata[36:6];
   assign req_len    = req_tdata[67:37];
   assign req_flags  = req_tdata[99:68];
   assign req_aux_a  = req_tdata[131:100];
   assign req_aux_b  = req_tdata[163:132];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;

   // Table limits
   assign full      = (cnt_ff >= cap_ff) || (cnt_ff >= CNT_W'(TABLE_DEPTH));
   assign bad_idx   = ({1'b0, req_sidx} >= cnt_ff);
   assign top_idx   = IDX_W'(cnt_ff - CNT_W'(1));
   assign scan_last = (idx_ff == '0);
   assign scan_end  = {1'b0, rd_data.offset} + {1'b0, rd_data.length};
   assign scan_max  = (scan_end > max_ff) ? scan_end : max_ff;
   assign rsp_load  = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_tready);

   // Sequence operations and drive the store
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      mask_in      = mask_ff;
      max_in       = max_ff;
      res_idx_in   = res_idx_ff;
      res_val_in   = res_val_ff;
      res_st_in    = res_st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      wr           = '0;
      rd_en        = 1'b0;
      rd_addr      = idx_ff - IDX_W'(1);

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               op_in      = req_func;
               mask_in    = req_flags;
               max_in     = '0;
               idx_in     = top_idx;
               res_idx_in = IDX_NONE;
               res_val_in = '0;
               res_st_in  = STAT_OK;
               state_in   = ST_RESP;
               case (req_func)
                  FN_ADD: begin
                     if (full) begin
                        res_st_in = STAT_FULL;
                     end else begin
                        wr.flags_en = 1'b1;
                        wr.data_en  = 1'b1;
                        wr.addr     = cnt_ff[IDX_W-1:0];
                        wr.flags    = req_flags;
                        wr.data     = '{req_off, req_len, req_aux_a, req_aux_b};
                        res_idx_in  = cnt_ff;
                        cnt_in      = cnt_ff + CNT_W'(1);
                     end
                  end
                  FN_CHANGE: begin
                     if (bad_idx) begin
                        res_st_in = STAT_BAD_IDX;
                     end else begin
                        wr.data_en = 1'b1;
                        wr.addr    = req_sidx;
                        wr.data    = '{req_off, req_len, req_aux_a, req_aux_b};
                        res_idx_in = {1'b0, req_sidx};
                     end
                  end
                  FN_SET_FLAGS: begin
                     if (bad_idx) begin
                        res_st_in = STAT_BAD_IDX;
                     end else begin
                        wr.flags_en = 1'b1;
                        wr.addr     = req_sidx;
                        wr.flags    = req_flags;
                        res_idx_in  = {1'b0, req_sidx};
                     end
                  end
                  FN_CLEAR: begin
                     cnt_in = '0;
                  end
                  FN_LAST_MASK, FN_UNUSED_PART: begin
                     // Walk entries from the top down
                     if (cnt_ff != '0) begin
                        rd_en    = 1'b1;
                        rd_addr  = top_idx;
                        state_in = ST_SCAN;
                     end
                  end
                  FN_ADD_SEI: begin
                     if (full) begin
                        res_st_in = STAT_FULL;
                     end else if (!req_prefix) begin
                        wr.flags_en = 1'b1;
                        wr.data_en  = 1'b1;
                        wr.addr     = cnt_ff[IDX_W-1:0];
                        wr.flags    = '0;
                        wr.data     = '{req_off, req_len, req_aux_a, ALL_ONES};
                        res_idx_in  = cnt_ff;
                        cnt_in      = cnt_ff + CNT_W'(1);
                     end else if (cnt_ff == '0) begin
                        pos_in   = '0;
                        state_in = ST_PUT;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = top_idx;
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SCAN: begin
            case (op_ff)
               FN_LAST_MASK: begin
                  if ((rd_flags & mask_ff) != '0) begin
                     res_idx_in = {1'b0, idx_ff};
                     state_in   = ST_RESP;
                  end else if (scan_last) begin
                     state_in = ST_RESP;
                  end else begin
                     rd_en  = 1'b1;
                     idx_in = idx_ff - IDX_W'(1);
                  end
               end
               FN_ADD_SEI: begin
                  if ((rd_flags & SEI_PREFIX_FLAG) != '0) begin
                     // Insert just above the last prefix entry
                     pos_in   = idx_ff + IDX_W'(1);
                     state_in = ST_PUT;
                  end else begin
                     // Move this entry up one place
                     wr.flags_en = 1'b1;
                     wr.data_en  = 1'b1;
                     wr.addr     = idx_ff + IDX_W'(1);
                     wr.flags    = rd_flags;
                     wr.data     = rd_data;
                     if (scan_last) begin
                        pos_in   = '0;
                        state_in = ST_PUT;
                     end else begin
                        rd_en  = 1'b1;
                        idx_in = idx_ff - IDX_W'(1);
                     end
                  end
               end
               FN_UNUSED_PART: begin
                  max_in = scan_max;
                  if (scan_last) begin
                     res_val_in = scan_max;
                     state_in   = ST_RESP;
                  end else begin
                     rd_en  = 1'b1;
                     idx_in = idx_ff - IDX_W'(1);
                  end
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end

         ST_PUT: begin
            // Write the prefix SEI entry
            wr.flags_en = 1'b1;
            wr.data_en  = 1'b1;
            wr.addr     = pos_ff;
            wr.flags    = SEI_PREFIX_FLAG;
            wr.data     = '{new_off_ff, new_len_ff, new_a_ff, ALL_ONES};
            res_idx_in  = {1'b0, pos_ff};
            cnt_in      = cnt_ff + CNT_W'(1);
            state_in    = ST_RESP;
         end

         ST_RESP: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            cap_ff <= csr_wdata;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      idx_ff     <= idx_in;
      pos_ff     <= pos_in;
      mask_ff    <= mask_in;
      max_ff     <= max_in;
      res_idx_ff <= res_idx_in;
      res_val_ff <= res_val_in;
      res_st_ff  <= res_st_in;
      if (req_xfer) begin
         new_off_ff <= req_off;
         new_len_ff <= req_len;
         new_a_ff   <= req_aux_a;
      end
      if (rsp_load) begin
         rsp_idx_ff <= res_idx_ff;
         rsp_val_ff <= res_val_ff;
         rsp_st_ff  <= res_st_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_st_ff, rsp_val_ff, rsp_idx_ff};

   sst_store u_store (
      .clock    (clock),
      .wr       (wr),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_flags (rd_flags),
      .rd_data  (rd_data)
   );

   // Checks
   `SST_ASSERT(a_cnt_bound, clock, reset, cnt_ff <= CNT_W'(TABLE_DEPTH))
   `SST_ASSERT(a_scan_nonempty, clock, reset, (state_ff != ST_SCAN) || (cnt_ff != '0))
   `SST_ASSERT(a_no_rw_clash, clock, reset,
      !(rd_en && (wr.flags_en || wr.data_en) && (wr.addr == rd_addr)))
   `SST_ASSERT(a_err_no_index, clock, reset,
      !(rsp_valid_ff && (rsp_st_ff != STAT_OK)) || (rsp_idx_ff == IDX_NONE))
   `SST_ASSERT_NEXT(a_cnt_step, clock, reset, 1'b1,
      (cnt_ff == '0) || (cnt_ff == $past(cnt_ff)) || (cnt_ff == $past(cnt_ff) + CNT_W'(1)))

endmodule
